@@ src/ipmc_pkg.sv @@
package ipmc_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int COUNT_OUT_W    = 32;
	localparam int NUM_COUNTERS   = 7;
	localparam int CNT_IDX_W      = $clog2(NUM_COUNTERS);

	// result categories; the first six double as counter indexes
	localparam logic [2:0] CAT_A       = 3'd0;
	localparam logic [2:0] CAT_B       = 3'd1;
	localparam logic [2:0] CAT_C       = 3'd2;
	localparam logic [2:0] CAT_D       = 3'd3;
	localparam logic [2:0] CAT_E       = 3'd4;
	localparam logic [2:0] CAT_INVALID = 3'd5;
	localparam logic [2:0] CAT_IGNORED = 3'd6;

	// counter slot that tracks private addresses
	localparam logic [CNT_IDX_W-1:0] CNT_PRIVATE = CNT_IDX_W'(6);

	typedef struct packed {
		logic       valid;
		logic [2:0] category;
		logic       is_private;
	} ipmc_res_t;

endpackage

@@ src/ipmc_in_if.sv @@
interface ipmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_record;

	modport source (output valid, output ch, output end_of_record, input ready);
	modport sink (input valid, input ch, input end_of_record, output ready);
endinterface

@@ src/ipmc_out_if.sv @@
interface ipmc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  category;
	logic        is_private;
	logic [31:0] count_a;
	logic [31:0] count_b;
	logic [31:0] count_c;
	logic [31:0] count_d;
	logic [31:0] count_e;
	logic [31:0] count_invalid;
	logic [31:0] count_private;

	modport source (
		output valid, output category, output is_private,
		output count_a, output count_b, output count_c, output count_d,
		output count_e, output count_invalid, output count_private,
		input ready
	);
	modport sink (
		input valid, input category, input is_private,
		input count_a, input count_b, input count_c, input count_d,
		input count_e, input count_invalid, input count_private,
		output ready
	);
endinterface

@@ src/ipmc_parse.sv @@
module ipmc_parse (
	input  logic                clk,
	input  logic                arst_n,
	ipmc_in_if.sink             item,
	input  logic                take,
	output ipmc_pkg::ipmc_res_t res_s2
);

	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [2:0] SEG_DONE = 3'd4;
	localparam logic [2:0] SEG_STOP = 3'd7;
	localparam logic [8:0] SEG_SAT  = 9'd256;

	// input stage
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       eor_s1;

	// parse state
	logic        in_mask_q, seg_ne_q, broken_q, addr_done_q, addr_bad_q, rec_ne_q;
	logic [2:0]  seg_idx_q;
	logic [8:0]  seg_val_q;
	logic [7:0]  oct1_q, oct2_q;
	logic [31:0] mask_q;

	logic        in_mask_d, seg_ne_d, broken_d, addr_done_d, addr_bad_d, rec_ne_d;
	logic [2:0]  seg_idx_d;
	logic [8:0]  seg_val_d;
	logic [7:0]  oct1_d, oct2_d;
	logic [31:0] mask_d;

	// segment close, shared by '.', '~' and end of record
	logic        seg_open, seg_good;
	logic [2:0]  cs_idx;
	logic [31:0] cs_mask;
	logic [7:0]  cs_oct1, cs_oct2;

	logic        s2_free, s1_adv;
	logic [11:0] acc;
	logic [31:0] inv_mask;
	logic        contig, addr_ok, mask_ok;
	ipmc_pkg::ipmc_res_t res;

	assign s2_free    = !res_s2.valid || take;
	assign s1_adv     = vld_s1 && s2_free;
	assign item.ready = !vld_s1 || s2_free;

	always_comb begin
		seg_open = seg_idx_q < SEG_DONE;
		seg_good = seg_ne_q && !seg_val_q[8];
		cs_idx   = seg_idx_q;
		cs_mask  = mask_q;
		cs_oct1  = oct1_q;
		cs_oct2  = oct2_q;
		if (seg_open) begin
			if (seg_good) begin
				cs_idx = seg_idx_q + 3'd1;
				if (in_mask_q) begin
					cs_mask = {mask_q[23:0], seg_val_q[7:0]};
				end else if (seg_idx_q == 3'd0) begin
					cs_oct1 = seg_val_q[7:0];
				end else if (seg_idx_q == 3'd1) begin
					cs_oct2 = seg_val_q[7:0];
				end
			end else begin
				cs_idx = SEG_STOP;
			end
		end
	end

	assign acc = {seg_val_q, 3'b000} + {2'b00, seg_val_q, 1'b0} + {4'd0, ch_s1 - CH_ZERO};

	// contiguous ones from the top, neither empty nor full
	assign inv_mask = ~cs_mask;
	assign contig   = (cs_mask != '0) && (cs_mask != '1) &&
		((inv_mask & (inv_mask + 32'd1)) == '0);
	assign addr_ok  = in_mask_q && addr_done_q && !addr_bad_q;
	assign mask_ok  = in_mask_q && (cs_idx == SEG_DONE) && !broken_q;

	always_comb begin
		res.valid      = 1'b0;
		res.category   = ipmc_pkg::CAT_INVALID;
		res.is_private = 1'b0;
		if (!addr_ok || !mask_ok) begin
			res.category = ipmc_pkg::CAT_INVALID;
		end else if (oct1_q == 8'd0 || oct1_q == 8'd127) begin
			res.category = ipmc_pkg::CAT_IGNORED;
		end else if (!contig) begin
			res.category = ipmc_pkg::CAT_INVALID;
		end else if (oct1_q <= 8'd126) begin
			res.category   = ipmc_pkg::CAT_A;
			res.is_private = oct1_q == 8'd10;
		end else if (oct1_q <= 8'd191) begin
			res.category   = ipmc_pkg::CAT_B;
			res.is_private = oct1_q == 8'd172 && oct2_q >= 8'd16 && oct2_q <= 8'd31;
		end else if (oct1_q <= 8'd223) begin
			res.category   = ipmc_pkg::CAT_C;
			res.is_private = oct1_q == 8'd192 && oct2_q == 8'd168;
		end else if (oct1_q <= 8'd239) begin
			res.category = ipmc_pkg::CAT_D;
		end else begin
			res.category = ipmc_pkg::CAT_E;
		end
		if (eor_s1 && rec_ne_q) begin
			res.valid = 1'b1;
		end
	end

	always_comb begin
		in_mask_d   = in_mask_q;
		seg_idx_d   = seg_idx_q;
		seg_val_d   = seg_val_q;
		seg_ne_d    = seg_ne_q;
		broken_d    = broken_q;
		addr_done_d = addr_done_q;
		addr_bad_d  = addr_bad_q;
		oct1_d      = oct1_q;
		oct2_d      = oct2_q;
		mask_d      = mask_q;
		rec_ne_d    = rec_ne_q;
		if (eor_s1) begin
			in_mask_d   = 1'b0;
			seg_idx_d   = 3'd0;
			seg_val_d   = '0;
			seg_ne_d    = 1'b0;
			broken_d    = 1'b0;
			addr_done_d = 1'b0;
			addr_bad_d  = 1'b0;
			oct1_d      = '0;
			oct2_d      = '0;
			mask_d      = '0;
			rec_ne_d    = 1'b0;
		end else begin
			rec_ne_d = 1'b1;
			if (ch_s1 == CH_TILDE) begin
				if (in_mask_q) begin
					broken_d = 1'b1;
				end else begin
					addr_done_d = cs_idx == SEG_DONE;
					addr_bad_d  = broken_q;
					oct1_d      = cs_oct1;
					oct2_d      = cs_oct2;
					in_mask_d   = 1'b1;
					seg_idx_d   = 3'd0;
					seg_val_d   = '0;
					seg_ne_d    = 1'b0;
					broken_d    = 1'b0;
				end
			end else if (ch_s1 == CH_DOT) begin
				seg_idx_d = cs_idx;
				mask_d    = cs_mask;
				oct1_d    = cs_oct1;
				oct2_d    = cs_oct2;
				seg_val_d = '0;
				seg_ne_d  = 1'b0;
			end else if (ch_s1 >= CH_ZERO && ch_s1 <= CH_NINE) begin
				if (seg_open) begin
					seg_val_d = (acc > 12'(SEG_SAT)) ? SEG_SAT : acc[8:0];
					seg_ne_d  = 1'b1;
				end
			end else begin
				broken_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			vld_s1 <= 1'b1;
		end else if (s2_free) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			ch_s1  <= item.ch;
			eor_s1 <= item.end_of_record;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_mask_q   <= 1'b0;
			seg_idx_q   <= 3'd0;
			seg_val_q   <= '0;
			seg_ne_q    <= 1'b0;
			broken_q    <= 1'b0;
			addr_done_q <= 1'b0;
			addr_bad_q  <= 1'b0;
			oct1_q      <= '0;
			oct2_q      <= '0;
			mask_q      <= '0;
			rec_ne_q    <= 1'b0;
		end else if (s1_adv) begin
			in_mask_q   <= in_mask_d;
			seg_idx_q   <= seg_idx_d;
			seg_val_q   <= seg_val_d;
			seg_ne_q    <= seg_ne_d;
			broken_q    <= broken_d;
			addr_done_q <= addr_done_d;
			addr_bad_q  <= addr_bad_d;
			oct1_q      <= oct1_d;
			oct2_q      <= oct2_d;
			mask_q      <= mask_d;
			rec_ne_q    <= rec_ne_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2.valid      <= 1'b0;
			res_s2.category   <= ipmc_pkg::CAT_INVALID;
			res_s2.is_private <= 1'b0;
		end else if (s2_free) begin
			res_s2.valid      <= s1_adv && res.valid;
			res_s2.category   <= res.category;
			res_s2.is_private <= res.is_private;
		end
	end

endmodule

@@ src/ipmc_tally.sv @@
module ipmc_tally #(
	parameter int COUNT_BITS = ipmc_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ipmc_pkg::ipmc_res_t res_s2,
	output logic                take,
	ipmc_out_if.source          result
);

	logic [COUNT_BITS-1:0] cnt_q [ipmc_pkg::NUM_COUNTERS];
	logic [ipmc_pkg::NUM_COUNTERS-1:0] hit;
	logic                  out_vld_q;
	logic [2:0]            cat_q;
	logic                  priv_q;
	logic                  load;

	assign take = !out_vld_q || result.ready;
	assign load = res_s2.valid && take;

	// ignored records hit no slot; the private slot follows the flag alone
	always_comb begin
		for (int i = 0; i < ipmc_pkg::NUM_COUNTERS; i++) begin
			if (ipmc_pkg::CNT_IDX_W'(i) == ipmc_pkg::CNT_PRIVATE) begin
				hit[i] = res_s2.is_private;
			end else begin
				hit[i] = res_s2.category == 3'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ipmc_pkg::NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (load) begin
			for (int i = 0; i < ipmc_pkg::NUM_COUNTERS; i++) begin
				if (hit[i] && cnt_q[i] != '1) begin
					cnt_q[i] <= cnt_q[i] + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= res_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cat_q  <= res_s2.category;
			priv_q <= res_s2.is_private;
		end
	end

	// counters only move on a load, so they hold with the word
	assign result.valid         = out_vld_q;
	assign result.category      = cat_q;
	assign result.is_private    = priv_q;
	assign result.count_a       = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CAT_A]);
	assign result.count_b       = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CAT_B]);
	assign result.count_c       = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CAT_C]);
	assign result.count_d       = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CAT_D]);
	assign result.count_e       = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CAT_E]);
	assign result.count_invalid = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CAT_INVALID]);
	assign result.count_private = ipmc_pkg::COUNT_OUT_W'(cnt_q[ipmc_pkg::CNT_PRIVATE]);

endmodule

@@ src/ip_mask_record_classifier_core.sv @@
// Path: a closing end-of-record word passes the input register, the classify register,
// then the output register with counter update, on its way to the result port.
// Throughput: one character word per cycle; only a full result port that is not ready stalls the chain.
// Reset: arst_n clears parse state, all seven counters and every valid flag at once;
// the block takes words in the first cycle after release.
module ip_mask_record_classifier_core #(
	parameter int COUNT_BITS = ipmc_pkg::COUNT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ipmc_in_if.sink    item,
	ipmc_out_if.source result
);

	ipmc_pkg::ipmc_res_t res_s2;
	logic                take;

	ipmc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (take),
		.res_s2 (res_s2)
	);

	ipmc_tally #(
		.COUNT_BITS (COUNT_BITS)
	) u_tally (
		.clk    (clk),
		.arst_n (arst_n),
		.res_s2 (res_s2),
		.take   (take),
		.result (result)
	);

endmodule
